// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/nma_pkg.sv
`timescale 1ns / 1ps

package nma_pkg;

   localparam int DATA_WIDTH        = 16;
   localparam int ACC_WIDTH_DEFAULT = 48;
   localparam int MODE_W            = 3;

   localparam int IN_FRAC = DATA_WIDTH / 2;
   localparam int W_FRAC  = DATA_WIDTH - 4;
   localparam int P_FRAC  = IN_FRAC + W_FRAC;
   localparam int STEP_SH = P_FRAC - 2;
   localparam int PROD_W  = 2 * DATA_WIDTH;

   // Magnitude clipped to 8.0 in Q.P_FRAC.
   localparam int MAG_W   = P_FRAC + 4;
   localparam int IDX_W   = MAG_W - STEP_SH;
   localparam int TANH_W  = 17;
   localparam int SIG_W   = TANH_W + 1;
   localparam int DIFF_W  = TANH_W;
   localparam int IMUL_W  = DIFF_W + STEP_SH;
   localparam int SQ_W    = 2 * SIG_W;

   localparam int TANH_ACT_SH = 16 - IN_FRAC;
   localparam int TANH_DER_SH = 32 - IN_FRAC;
   localparam int SIG_ACT_SH  = 17 - IN_FRAC;
   localparam int SIG_DER_SH  = 34 - IN_FRAC;

   localparam logic [TANH_W-1:0] TANH_ONE = TANH_W'(1) << 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_LINEAR     = 3'd0,
      MODE_SYM_THRESH = 3'd1,
      MODE_THRESH     = 3'd2,
      MODE_TANH       = 3'd3,
      MODE_SIGMOID    = 3'd4,
      MODE_RELU       = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_EVAL,
      ST_LOOKUP,
      ST_INTERP,
      ST_SHAPE,
      ST_SQUARE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_in;
      logic acc_update;
      logic first;
      logic eval;
      logic lookup;
      logic interp;
      logic shape;
      logic square;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

   // Samples of tanh(k/4) in Q1.16; every index past the table is 1.0.
   function automatic logic [TANH_W-1:0] tanh_rom(input logic [IDX_W-1:0] idx);
      logic [TANH_W-1:0] val;
      case (idx)
         6'd0:    val = 17'd0;
         6'd1:    val = 17'd16051;
         6'd2:    val = 17'd30285;
         6'd3:    val = 17'd41625;
         6'd4:    val = 17'd49912;
         6'd5:    val = 17'd55593;
         6'd6:    val = 17'd59320;
         6'd7:    val = 17'd61694;
         6'd8:    val = 17'd63179;
         6'd9:    val = 17'd64096;
         6'd10:   val = 17'd64659;
         6'd11:   val = 17'd65003;
         6'd12:   val = 17'd65212;
         6'd13:   val = 17'd65339;
         6'd14:   val = 17'd65417;
         6'd15:   val = 17'd65464;
         6'd16:   val = 17'd65492;
         6'd17:   val = 17'd65509;
         6'd18:   val = 17'd65520;
         6'd19:   val = 17'd65526;
         6'd20:   val = 17'd65530;
         6'd21:   val = 17'd65532;
         6'd22:   val = 17'd65534;
         6'd23:   val = 17'd65535;
         6'd24:   val = 17'd65535;
         default: val = TANH_ONE;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/nma_if.sv
`timescale 1ns / 1ps

interface nma_req_if import nma_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] in_value;
   logic signed [DATA_WIDTH-1:0] weight;
   logic signed [DATA_WIDTH-1:0] bias;
   logic                         last;

   modport source (output valid, output in_value, output weight, output bias,
                   output last, input ready);
   modport sink (input valid, input in_value, input weight, input bias,
                 input last, output ready);
endinterface

interface nma_rsp_if import nma_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] activation;
   logic signed [DATA_WIDTH-1:0] derivative;
   logic                         saturated;

   modport source (output valid, output activation, output derivative,
                   output saturated, input ready);
   modport sink (input valid, input activation, input derivative,
                 input saturated, output ready);
endinterface

interface nma_csr_if import nma_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] activation_mode;

   modport source (output valid, output activation_mode, input ready);
   modport sink (input valid, input activation_mode, output ready);
endinterface

// File: rtl/nma_datapath.sv
`timescale 1ns / 1ps

module nma_datapath import nma_pkg::*; #(
   parameter int ACC_WIDTH = ACC_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output status_type                   status,
   input  logic signed [DATA_WIDTH-1:0] in_value,
   input  logic signed [DATA_WIDTH-1:0] weight,
   input  logic signed [DATA_WIDTH-1:0] bias,
   input  logic                         last,
   input  logic                         csr_write,
   input  logic [MODE_W-1:0]            csr_data,
   output logic signed [DATA_WIDTH-1:0] activation,
   output logic signed [DATA_WIDTH-1:0] derivative,
   output logic                         saturated
);

   localparam logic [ACC_WIDTH-1:0] MAG_LIM = ACC_WIDTH'(1) << (P_FRAC + 3);
   localparam logic [DATA_WIDTH-1:0] ONE_Q  = DATA_WIDTH'(1) << IN_FRAC;
   localparam logic [DATA_WIDTH-1:0] MAX_Q  = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] MIN_Q  = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
   localparam logic [SIG_W-1:0] SIG_ONE     = SIG_W'(TANH_ONE);
   localparam logic [SIG_W-1:0] SIG_TWO     = SIG_W'(1) << 17;
   localparam logic [SQ_W-1:0] SQ_ONE       = SQ_W'(1) << 32;

   mode_type mode_ff, mode_in;

   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [DATA_WIDTH-1:0] bias_ff;
   logic                         last_ff;
   logic signed [ACC_WIDTH-1:0]  acc_ff, acc_in;

   logic                  neg_ff, zero_ff, lin_sat_ff;
   logic [MAG_W-1:0]      mag_ff;
   logic [DATA_WIDTH-1:0] lin_ff;

   logic [IDX_W-1:0]   idx;
   logic [STEP_SH-1:0] frac;
   logic [MAG_W-1:0]   tmag;
   logic [ACC_WIDTH-1:0] mag_full;
   logic signed [ACC_WIDTH-1:0] sh;
   logic [ACC_WIDTH-DATA_WIDTH:0] sh_top;
   logic                 lin_sat;

   logic                 top_ff;
   logic [TANH_W-1:0]    lo_ff;
   logic [DIFF_W-1:0]    diff_ff;
   logic [STEP_SH-1:0]   frac_ff;
   logic [IMUL_W-1:0]    interp_mul;
   logic [TANH_W-1:0]    t_ff, t_in;
   logic [SIG_W-1:0]     s_ff, sc_ff;
   logic [SIG_W-1:0]     op_a, op_b;
   logic [SQ_W-1:0]      sq_ff;

   logic [TANH_W-1:0]     tanh_r;
   logic [SQ_W-1:0]       tanh_der, sig_der;
   logic [SIG_W-1:0]      sig_act;
   logic [DATA_WIDTH-1:0] act_in, der_in;
   logic                  sat_in;
   logic [DATA_WIDTH-1:0] act_ff, der_ff;
   logic                  sat_ff;

   assign prod_in = in_value * weight;
   assign mode_in = csr_write ? mode_type'(csr_data) : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LINEAR;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         prod_ff <= prod_in;
         bias_ff <= bias;
         last_ff <= last;
      end
   end

   assign status.last = last_ff;

   always_comb begin
      if (cmd.first) begin
         acc_in = (ACC_WIDTH'(bias_ff) <<< W_FRAC) + ACC_WIDTH'(prod_ff);
      end else begin
         acc_in = acc_ff + ACC_WIDTH'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_update) begin
         acc_ff <= acc_in;
      end
   end

   // Sign, magnitude and the saturated linear value of the sum.
   always_comb begin
      mag_full = acc_ff[ACC_WIDTH-1] ? (ACC_WIDTH'(0) - acc_ff) : acc_ff;
      sh       = acc_ff >>> W_FRAC;
      sh_top   = sh[ACC_WIDTH-1:DATA_WIDTH-1];
      lin_sat  = !((&sh_top) || (~|sh_top));
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         neg_ff     <= acc_ff[ACC_WIDTH-1];
         zero_ff    <= (acc_ff == '0);
         mag_ff     <= (mag_full > MAG_LIM) ? MAG_LIM[MAG_W-1:0] : mag_full[MAG_W-1:0];
         lin_sat_ff <= lin_sat;
         if (lin_sat) begin
            lin_ff <= acc_ff[ACC_WIDTH-1] ? MIN_Q : MAX_Q;
         end else begin
            lin_ff <= sh[DATA_WIDTH-1:0];
         end
      end
   end

   // Sigmoid looks up tanh at half the sum.
   always_comb begin
      tmag = (mode_ff == MODE_SIGMOID) ? (mag_ff >> 1) : mag_ff;
      idx  = tmag[MAG_W-1:STEP_SH];
      frac = tmag[STEP_SH-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         top_ff  <= idx[IDX_W-1];
         lo_ff   <= tanh_rom(idx);
         diff_ff <= tanh_rom(idx + IDX_W'(1)) - tanh_rom(idx);
         frac_ff <= frac;
      end
   end

   always_comb begin
      interp_mul = IMUL_W'(diff_ff) * IMUL_W'(frac_ff);
      t_in       = top_ff ? TANH_ONE : (lo_ff + interp_mul[IMUL_W-1:STEP_SH]);
   end

   always_ff @(posedge clock) begin
      if (cmd.interp) begin
         t_ff <= t_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shape) begin
         if (neg_ff) begin
            s_ff  <= SIG_ONE - SIG_W'(t_ff);
            sc_ff <= SIG_TWO - (SIG_ONE - SIG_W'(t_ff));
         end else begin
            s_ff  <= SIG_ONE + SIG_W'(t_ff);
            sc_ff <= SIG_TWO - (SIG_ONE + SIG_W'(t_ff));
         end
      end
   end

   // One multiplier serves the tanh square and the sigmoid product.
   always_comb begin
      op_a = (mode_ff == MODE_TANH) ? SIG_W'(t_ff) : s_ff;
      op_b = (mode_ff == MODE_TANH) ? SIG_W'(t_ff) : sc_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sq_ff <= SQ_W'(op_a) * SQ_W'(op_b);
      end
   end

   always_comb begin
      tanh_r   = (t_ff + (TANH_W'(1) << (TANH_ACT_SH - 1))) >> TANH_ACT_SH;
      tanh_der = (SQ_ONE - sq_ff + (SQ_W'(1) << (TANH_DER_SH - 1))) >> TANH_DER_SH;
      sig_act  = (s_ff + (SIG_W'(1) << (SIG_ACT_SH - 1))) >> SIG_ACT_SH;
      sig_der  = (sq_ff + (SQ_W'(1) << (SIG_DER_SH - 1))) >> SIG_DER_SH;
      act_in   = '0;
      der_in   = '0;
      sat_in   = 1'b0;
      case (mode_ff)
         MODE_LINEAR: begin
            act_in = lin_ff;
            der_in = ONE_Q;
            sat_in = lin_sat_ff;
         end
         MODE_SYM_THRESH: begin
            act_in = neg_ff ? (DATA_WIDTH'(0) - ONE_Q) : ONE_Q;
            der_in = zero_ff ? ONE_Q : '0;
         end
         MODE_THRESH: begin
            act_in = neg_ff ? '0 : ONE_Q;
            der_in = zero_ff ? ONE_Q : '0;
         end
         MODE_TANH: begin
            act_in = neg_ff ? (DATA_WIDTH'(0) - DATA_WIDTH'(tanh_r)) : DATA_WIDTH'(tanh_r);
            der_in = DATA_WIDTH'(tanh_der);
         end
         MODE_SIGMOID: begin
            act_in = DATA_WIDTH'(sig_act);
            der_in = DATA_WIDTH'(sig_der);
         end
         MODE_RELU: begin
            if (!neg_ff && !zero_ff) begin
               act_in = lin_ff;
               der_in = ONE_Q;
               sat_in = lin_sat_ff;
            end
         end
         default: begin
            act_in = '0;
            der_in = '0;
            sat_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         act_ff <= act_in;
         der_ff <= der_in;
         sat_ff <= sat_in;
      end
   end

   assign activation = act_ff;
   assign derivative = der_ff;
   assign saturated  = sat_ff;

endmodule

// File: rtl/nma_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nma_ctrl import nma_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      first_pending_ff, first_pending_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            state_in = status.last ? ST_EVAL : ST_IDLE;
         end
         ST_EVAL:   state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_INTERP;
         ST_INTERP: state_in = ST_SHAPE;
         ST_SHAPE:  state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_FINISH;
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      cmd.first = first_pending_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         ST_ACC:    cmd.acc_update = 1'b1;
         ST_EVAL:   cmd.eval       = 1'b1;
         ST_LOOKUP: cmd.lookup     = 1'b1;
         ST_INTERP: cmd.interp     = 1'b1;
         ST_SHAPE:  cmd.shape      = 1'b1;
         ST_SQUARE: cmd.square     = 1'b1;
         ST_FINISH: cmd.out_load   = slot_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      first_pending_in = first_pending_ff;
      if (cmd.acc_update) begin
         first_pending_in = status.last;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         first_pending_ff <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         first_pending_ff <= first_pending_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_CLK(a_load_free, !cmd.out_load || !rsp_valid_ff || rsp_ready, "result overwritten")
   `ASSERT_NEXT(a_accept_acc, state_ff == ST_IDLE && req_valid, state_ff == ST_ACC, "item skipped")
   `ASSERT_NEXT(a_last_first, state_ff == ST_ACC && status.last, first_pending_ff, "sum not restarted")
   `ASSERT_CLK(a_rsp_origin, !$rose(rsp_valid_ff) || $past(state_ff) == ST_FINISH, "stray result")

endmodule

// File: rtl/neuron_mac_activation.sv
`timescale 1ns / 1ps
// Neuron multiply-accumulate with activation.
// The req channel carries one (in_value, weight) pair per item, with the
// neuron bias taken on the first pair of a vector and last marking the
// final pair. Each pair's product is added into a wide accumulator.
// A pair without last passes through the accumulate step and produces
// nothing; no next item is accepted until the block is back in idle.
// On a pair with last the sum passes through a sequencer of evaluation
// steps (magnitude, table lookup, interpolation, shaping, one shared
// multiplier) and the result item is registered onto rsp from the final
// step, and the block is ready for the next item as the result appears.
// The csr channel writes the activation mode; it is always ready.
// The rsp output is registered, so a new vector is accepted and summed
// while a result waits. If the receiver stalls, the block holds its next
// result in the last step and accepts no item until the output frees.
// Reset clears the mode to linear, empties the output and arms the next
// pair to start a new vector.

module neuron_mac_activation import nma_pkg::*; #(
   parameter int ACC_WIDTH = ACC_WIDTH_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   nma_req_if.sink  req_bus,
   nma_rsp_if.source rsp_bus,
   nma_csr_if.sink  csr_bus
);

   cmd_type    cmd;
   status_type status;

   assign csr_bus.ready = 1'b1;

   nma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   nma_datapath #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_value   (req_bus.in_value),
      .weight     (req_bus.weight),
      .bias       (req_bus.bias),
      .last       (req_bus.last),
      .csr_write  (csr_bus.valid),
      .csr_data   (csr_bus.activation_mode),
      .activation (rsp_bus.activation),
      .derivative (rsp_bus.derivative),
      .saturated  (rsp_bus.saturated)
   );

endmodule
